### src/code_history_ring_buffer_macros.svh
// Assertion macros for the code history ring buffer.
// Used by the top level; expects signals clk and rst in scope.
`ifndef CODE_HISTORY_RING_BUFFER_MACROS_SVH
`define CODE_HISTORY_RING_BUFFER_MACROS_SVH

// same-cycle implication
`define CHRB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("chrb assertion failed");

// next-cycle implication
`define CHRB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("chrb assertion failed");

`endif

### src/chrb_pkg.sv
// Shared types and constants for the code history ring buffer.
// No dependencies.
`timescale 1ns / 1ps

package chrb_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int CODE_W       = 8;
  localparam int NUM_W        = 32;
  localparam int MODE_W       = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH  = 2'd0,
    MODE_GET   = 2'd1,
    MODE_POP   = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_ACCESS,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;    // latch input word
    logic eval;    // range checks, slot offset
    logic access;  // store read or write, counter update
    logic finish;  // load output register
  } cmd_t;

  typedef struct packed {
    logic out_stall;  // output register holds a word not yet taken
  } sts_t;

endpackage

### src/chrb_ctrl.sv
// Controller for the code history ring buffer: sequences one word at a time.
// Depends on chrb_pkg.
`timescale 1ns / 1ps

module chrb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  chrb_pkg::sts_t    sts,
  output chrb_pkg::cmd_t    cmd
);

  chrb_pkg::state_t state;
  chrb_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chrb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      chrb_pkg::ST_IDLE: begin
        if (in_valid) state_next = chrb_pkg::ST_EVAL;
      end
      chrb_pkg::ST_EVAL:   state_next = chrb_pkg::ST_ACCESS;
      chrb_pkg::ST_ACCESS: state_next = chrb_pkg::ST_DONE;
      chrb_pkg::ST_DONE: begin
        if (!sts.out_stall) state_next = chrb_pkg::ST_IDLE;
      end
      default: state_next = chrb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      chrb_pkg::ST_IDLE: begin
        // no word is taken while reset is applied
        in_ready = !rst;
        cmd.load = in_valid && !rst;
      end
      chrb_pkg::ST_EVAL:   cmd.eval = 1'b1;
      chrb_pkg::ST_ACCESS: cmd.access = 1'b1;
      chrb_pkg::ST_DONE:   cmd.finish = !sts.out_stall;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### src/chrb_dp.sv
// Datapath for the code history ring buffer: counters, code store, output register.
// Depends on chrb_pkg; driven by chrb_ctrl commands.
`timescale 1ns / 1ps

module chrb_dp #(
  parameter int CAPACITY = chrb_pkg::CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  chrb_pkg::cmd_t               cmd,
  output chrb_pkg::sts_t               sts,
  input  chrb_pkg::mode_t              in_mode,
  input  logic [chrb_pkg::CODE_W-1:0]  in_code,
  input  logic [chrb_pkg::NUM_W-1:0]   in_num,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_found,
  output logic [chrb_pkg::CODE_W-1:0]  out_code,
  output logic [chrb_pkg::NUM_W-1:0]   out_oldest,
  output logic [chrb_pkg::NUM_W-1:0]   out_newest
);

  localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  localparam logic [CNT_W-1:0]  CAP_CNT  = CNT_W'(CAPACITY);
  localparam logic [SLOT_W:0]   CAP_SUM  = (SLOT_W + 1)'(CAPACITY);
  localparam logic [SLOT_W-1:0] LAST_SLT = SLOT_W'(CAPACITY - 1);

  logic [chrb_pkg::CODE_W-1:0] mem [CAPACITY];

  // latched input word
  chrb_pkg::mode_t             op_mode;
  logic [chrb_pkg::CODE_W-1:0] op_code;
  logic [chrb_pkg::NUM_W-1:0]  op_num;

  // architectural state; oldest tracks pushed - held
  logic [SLOT_W-1:0]           head;
  logic [CNT_W-1:0]            held;
  logic [chrb_pkg::NUM_W-1:0]  pushed;
  logic [chrb_pkg::NUM_W-1:0]  oldest;
  logic [chrb_pkg::NUM_W-1:0]  cursor;

  // eval results
  logic                        hit;
  logic                        full;
  logic [SLOT_W-1:0]           rel;
  logic [chrb_pkg::CODE_W-1:0] rdata;

  logic                        hit_next;
  logic [SLOT_W-1:0]           rel_next;
  logic                        is_full;
  logic                        nonempty;
  logic                        cur_lt_old;
  logic [chrb_pkg::NUM_W-1:0]  num_off;
  logic [chrb_pkg::NUM_W-1:0]  cur_off;
  logic [SLOT_W:0]             addr_sum;
  logic [SLOT_W-1:0]           addr;

  assign is_full    = (held == CAP_CNT);
  assign nonempty   = (held != '0);
  assign cur_lt_old = (cursor < oldest);
  assign num_off    = op_num - oldest;
  assign cur_off    = cursor - oldest;

  always_comb begin
    hit_next = 1'b0;
    rel_next = '0;
    unique case (op_mode)
      chrb_pkg::MODE_PUSH: begin
        rel_next = is_full ? '0 : held[SLOT_W-1:0];
      end
      chrb_pkg::MODE_GET: begin
        hit_next = nonempty && (op_num >= oldest) && (op_num < pushed);
        rel_next = num_off[SLOT_W-1:0];
      end
      chrb_pkg::MODE_POP: begin
        // cursor is clamped up to oldest before the check
        hit_next = nonempty && (cur_lt_old ? (oldest < pushed) : (cursor < pushed));
        rel_next = cur_lt_old ? '0 : cur_off[SLOT_W-1:0];
      end
      chrb_pkg::MODE_CLEAR: begin
        hit_next = 1'b0;
      end
      default: hit_next = 1'b0;
    endcase
  end

  // slot = (head + rel) mod CAPACITY, rel < CAPACITY
  assign addr_sum = {1'b0, head} + {1'b0, rel};
  always_comb begin
    if (addr_sum >= CAP_SUM) begin
      addr = SLOT_W'(addr_sum - CAP_SUM);
    end else begin
      addr = addr_sum[SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_mode <= in_mode;
      op_code <= in_code;
      op_num  <= in_num;
    end
    if (cmd.eval) begin
      hit  <= hit_next;
      rel  <= rel_next;
      full <= is_full;
    end
  end

  // code store, single port
  always_ff @(posedge clk) begin
    if (cmd.access) begin
      if (op_mode == chrb_pkg::MODE_PUSH) begin
        mem[addr] <= op_code;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      held   <= '0;
      pushed <= '0;
      oldest <= '0;
      cursor <= '0;
    end else begin
      if (cmd.eval) begin
        if (op_mode == chrb_pkg::MODE_POP && nonempty && cur_lt_old) begin
          cursor <= oldest;
        end else if (op_mode == chrb_pkg::MODE_CLEAR) begin
          cursor <= pushed;
        end
      end
      if (cmd.access) begin
        if (op_mode == chrb_pkg::MODE_PUSH) begin
          pushed <= pushed + 1'b1;
          if (full) begin
            head   <= (head == LAST_SLT) ? '0 : head + 1'b1;
            oldest <= oldest + 1'b1;
          end else begin
            held <= held + 1'b1;
          end
        end else if (op_mode == chrb_pkg::MODE_POP && hit) begin
          cursor <= cursor + 1'b1;
        end
      end
      // push drags the cursor up to the new oldest
      if (cmd.finish && op_mode == chrb_pkg::MODE_PUSH && cur_lt_old) begin
        cursor <= oldest;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_found  <= hit;
      out_code   <= hit ? rdata : '0;
      out_oldest <= oldest;
      out_newest <= pushed - 1'b1;
    end
  end

  assign sts.out_stall = out_valid && !out_ready;

endmodule

### src/code_history_ring_buffer.sv
// Top level of the code history ring buffer: stream ports, controller and datapath.
// Depends on chrb_pkg, chrb_ctrl, chrb_dp and code_history_ring_buffer_macros.svh.
//
//   channel | dir | tdata                                   | tuser
//   s_      | in  | code[7:0], seq_number[39:8]             | mode[1:0]
//   m_      | out | read_code[7:0], oldest[39:8], newest[71:40] | found
//
// One word at a time: accept, evaluate, store access, result load;
// the next word is taken in the cycle after the result is loaded. The store
// access stage does one single-port read or write, with registered read data.
// Reset clears the counters, cursor, output valid and controller state; the store is not cleared.
// A result waiting in the output register stalls only the result load step.
`timescale 1ns / 1ps
`include "code_history_ring_buffer_macros.svh"

module code_history_ring_buffer #(
  parameter int CAPACITY = chrb_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // code[7:0], seq_number[39:8]
  input  logic [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // read_code[7:0], oldest_number[39:8], newest_number[71:40]
  output logic        m_tuser    // found[0]
);

  chrb_pkg::cmd_t               cmd;
  chrb_pkg::sts_t               sts;
  logic [chrb_pkg::CODE_W-1:0]  rd_code;
  logic [chrb_pkg::NUM_W-1:0]   oldest_num;
  logic [chrb_pkg::NUM_W-1:0]   newest_num;

  chrb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  chrb_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_mode    (chrb_pkg::mode_t'(s_tuser)),
    .in_code    (s_tdata[7:0]),
    .in_num     (s_tdata[39:8]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_found  (m_tuser),
    .out_code   (rd_code),
    .out_oldest (oldest_num),
    .out_newest (newest_num)
  );

  assign m_tdata = {newest_num, oldest_num, rd_code};

  `CHRB_ASSERT_NEXT(a_accept_starts_eval, s_tvalid && s_tready, cmd.eval && !s_tready)
  `CHRB_ASSERT_NEXT(a_eval_then_access, cmd.eval, cmd.access)
  `CHRB_ASSERT_IMPL(a_miss_code_zero, m_tvalid && !m_tuser, m_tdata[7:0] == 8'd0)

endmodule
